FILE: rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the scanline filter reconstruction core
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  // widths fixed by the beat and register formats
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ROW_LEN_W  = 13;
  localparam int unsigned BPP_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = ROW_LEN_W;

  // register reset values
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 13'd4096;
  localparam logic [BPP_W-1:0]     BPP_RESET     = 4'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'd1;

  // filter kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_SUB   = 2'd1,
    KIND_UP    = 2'd2,
    KIND_PAETH = 2'd3
  } kind_e;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage : sfr_pkg

`default_nettype wire

FILE: rtl/core/sfr_stream_if.sv
// ----------------------------------------------------------------------------
// sfr stream interfaces
// valid/ready channels for filtered input beats and reconstructed output beats
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] kind;
  logic       no_previous_row;

  modport source (output valid, output data_byte, output kind,
                  output no_previous_row, input ready);
  modport sink   (input valid, input data_byte, input kind,
                  input no_previous_row, output ready);
endinterface : sfr_in_if

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] recon_byte;
  logic       last_in_row;

  modport source (output valid, output recon_byte, output last_in_row, input ready);
  modport sink   (input valid, input recon_byte, input last_in_row, output ready);
endinterface : sfr_out_if

`default_nettype wire

FILE: rtl/core/sfr_line_mem.sv
// ----------------------------------------------------------------------------
// sfr_line_mem
// previous-row line memory, one write and one registered read per cycle,
// with same-cycle write-to-read forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_line_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire sfr_pkg::byte_t wr_data_i,
  output sfr_pkg::byte_t     rd_data_o
);
  import sfr_pkg::*;

  byte_t mem_q [DEPTH];
  byte_t rd_q;
  byte_t byp_data_q;
  logic  byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // read and write on the same entry in one cycle: take the new byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule : sfr_line_mem

`default_nettype wire

FILE: rtl/core/sfr_predictor.sv
// ----------------------------------------------------------------------------
// sfr_predictor
// filter prediction (none, sub, up, paeth) and modulo-256 add
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_predictor (
  input  wire sfr_pkg::kind_e kind_i,
  input  wire sfr_pkg::byte_t data_i,
  input  wire sfr_pkg::byte_t a_i,
  input  wire sfr_pkg::byte_t b_i,
  input  wire sfr_pkg::byte_t c_i,
  output sfr_pkg::byte_t      recon_o
);
  import sfr_pkg::*;

  logic signed [10:0] a_s, b_s, c_s;
  logic signed [10:0] da, db, dc;
  logic        [10:0] pa, pb, pc;
  byte_t paeth;
  byte_t pred;

  always_comb begin
    a_s = $signed({3'b000, a_i});
    b_s = $signed({3'b000, b_i});
    c_s = $signed({3'b000, c_i});
    // p - a = b - c, p - b = a - c, p - c = a + b - 2c
    da = b_s - c_s;
    db = a_s - c_s;
    dc = a_s + b_s - (c_s <<< 1);
    pa = da[10] ? 11'(-da) : 11'(da);
    pb = db[10] ? 11'(-db) : 11'(db);
    pc = dc[10] ? 11'(-dc) : 11'(dc);
    if ((pa <= pb) && (pa <= pc)) begin
      paeth = a_i;
    end else if (pb <= pc) begin
      paeth = b_i;
    end else begin
      paeth = c_i;
    end
    case (kind_i)
      KIND_SUB:   pred = a_i;
      KIND_UP:    pred = b_i;
      KIND_PAETH: pred = paeth;
      default:    pred = '0;
    endcase
    recon_o = data_i + pred;
  end

endmodule : sfr_predictor

`default_nettype wire

FILE: rtl/core/scanline_filter_reconstruct_core.sv
// ----------------------------------------------------------------------------
// scanline_filter_reconstruct_core
// Undoes the none/sub/up/paeth scanline filters, one byte per beat.
//
// in_ch_i carries a filtered byte, its filter kind and a flag that the row has
// no row above. out_ch_o carries the reconstructed byte and a last-in-row flag.
// cfg_we_i/cfg_idx_i/cfg_wdata_i write row_length (index 0) and
// bytes_per_pixel (index 1); write them only while the core is idle.
// Throughput is one beat per cycle while the receiver takes every beat. A beat
// that is taken sits in the stage register while the line memory read
// completes, and its result is loaded from there into the output register.
// The line memory read (address = column counter) is issued at accept time, so
// the registered memory read sets the depth of the pipe; a write to the same
// column in the accept cycle is forwarded.
// Reset clears the column counter, the neighbor windows and the valid flags
// and sets row_length to 4096 and bytes_per_pixel to 1. The line memory is
// not cleared: the first row must arrive with no_previous_row set.
// When the receiver stalls the output register holds its beat; the stage
// register still fills, and in_ch_i.ready drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module scanline_filter_reconstruct_core #(
  parameter int unsigned MAX_ROW_BYTES = 4096,
  parameter int unsigned MAX_BPP       = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  sfr_in_if.sink                              in_ch_i,
  sfr_out_if.source                           out_ch_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sfr_pkg::*;

  // column address width, window select width, row length compare width
  localparam int unsigned AW = $clog2(MAX_ROW_BYTES);
  localparam int unsigned BW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
  localparam int unsigned LW = (ROW_LEN_W > AW + 1) ? ROW_LEN_W : AW + 1;

  // configuration registers
  logic [ROW_LEN_W-1:0] row_len_q;
  logic [BPP_W-1:0]     bpp_q;

  // effective settings after clamping
  logic [LW-1:0]  len_x, len_eff;
  logic [BPP_W:0] bpp_x, bpp_eff;
  logic [BW-1:0]  win_sel;

  // column tracking
  logic [AW-1:0] col_q, col_d;
  logic          last;

  // handshake
  logic accept, s1_fire, in_ready;

  // stage register
  logic          s1_v_q;
  byte_t         s1_data_q;
  kind_e         s1_kind_q;
  logic          s1_noprev_q;
  logic [AW-1:0] s1_col_q;
  logic          s1_last_q;

  // neighbor windows, index 0 is the newest byte
  byte_t left_q  [MAX_BPP];
  byte_t upl_q   [MAX_BPP];
  byte_t left_eff[MAX_BPP];
  byte_t upl_eff [MAX_BPP];

  byte_t mem_rd;
  byte_t above, a_byte, c_byte, recon;

  // output register
  logic  out_v_q;
  byte_t out_recon_q;
  logic  out_last_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= ROW_LEN_RESET;
      bpp_q     <= BPP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_LENGTH:      row_len_q <= cfg_wdata_i;
        CFG_BYTES_PER_PIXEL: bpp_q     <= cfg_wdata_i[BPP_W-1:0];
        default:             ;
      endcase
    end
  end

  // zero means one; values above the maxima saturate
  always_comb begin
    len_x = LW'(row_len_q);
    if (len_x == '0) begin
      len_eff = LW'(1);
    end else if (len_x > LW'(MAX_ROW_BYTES)) begin
      len_eff = LW'(MAX_ROW_BYTES);
    end else begin
      len_eff = len_x;
    end
    bpp_x = {1'b0, bpp_q};
    if (bpp_x == '0) begin
      bpp_eff = (BPP_W + 1)'(1);
    end else if (32'(bpp_x) > MAX_BPP) begin
      bpp_eff = (BPP_W + 1)'(MAX_BPP);
    end else begin
      bpp_eff = bpp_x;
    end
    win_sel = BW'(bpp_eff - (BPP_W + 1)'(1));
  end

  // ---------------------------------------------------------------- handshake
  assign s1_fire        = s1_v_q && (!out_v_q || out_ch_o.ready);
  assign in_ready       = !s1_v_q || s1_fire;
  assign accept         = in_ch_i.valid && in_ready;
  assign in_ch_i.ready  = in_ready;

  // ---------------------------------------------------------------- column
  // the row end is known at accept time; a row length lowered below the
  // current position ends the row on this byte
  assign last  = (LW'(col_q) + LW'(1)) >= len_eff;
  assign col_d = last ? '0 : col_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s1_fire) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q   <= in_ch_i.data_byte;
      s1_kind_q   <= kind_e'(in_ch_i.kind);
      s1_noprev_q <= in_ch_i.no_previous_row;
      s1_col_q    <= col_q;
      s1_last_q   <= last;
    end
  end

  // previous row, read at accept, written when the stage completes
  sfr_line_mem #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (AW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i (recon),
    .rd_data_o (mem_rd)
  );

  // windows read as zero at the start of a row
  always_comb begin
    for (int i = 0; i < MAX_BPP; i++) begin
      left_eff[i] = (s1_col_q == '0) ? '0 : left_q[i];
      upl_eff[i]  = (s1_col_q == '0) ? '0 : upl_q[i];
    end
    above  = s1_noprev_q ? '0 : mem_rd;
    a_byte = left_eff[win_sel];
    c_byte = s1_noprev_q ? '0 : upl_eff[win_sel];
  end

  sfr_predictor u_predictor (
    .kind_i  (s1_kind_q),
    .data_i  (s1_data_q),
    .a_i     (a_byte),
    .b_i     (above),
    .c_i     (c_byte),
    .recon_o (recon)
  );

  // shift the new byte and its above byte into the windows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BPP; i++) begin
        left_q[i] <= '0;
        upl_q[i]  <= '0;
      end
    end else if (s1_fire) begin
      for (int i = 1; i < MAX_BPP; i++) begin
        left_q[i] <= left_eff[i-1];
        upl_q[i]  <= upl_eff[i-1];
      end
      left_q[0] <= recon;
      upl_q[0]  <= above;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_fire) begin
      out_v_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_recon_q <= recon;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_ch_o.valid       = out_v_q;
  assign out_ch_o.recon_byte  = out_recon_q;
  assign out_ch_o.last_in_row = out_last_q;

endmodule : scanline_filter_reconstruct_core

`default_nettype wire
